// File: rtl/hgw_pkg.sv
// shared constants for the hourglass window maximum block
package hgw_pkg;

    // row length register
    localparam int unsigned ROW_LENGTH_W     = 11;
    localparam int unsigned ROW_LENGTH_RESET = 3;
    localparam int unsigned MIN_ROW_LENGTH   = 3;

    // rows of a window and extra bits of a seven-term sum
    localparam int unsigned WINDOW_ROWS  = 3;
    localparam int unsigned SUM_GROWTH_W = 3;

endpackage

// File: rtl/hgw_channels.sv
// valid/ready channel interfaces for matrix elements and results
interface hgw_element_if #(
    parameter int ELEMENT_WIDTH = 16
);
    logic                            valid;
    logic                            ready;
    logic signed [ELEMENT_WIDTH-1:0] element_value;
    logic                            last_element;

    modport source (output valid, output element_value, output last_element, input ready);
    modport sink   (input valid, input element_value, input last_element, output ready);
endinterface

interface hgw_result_if #(
    parameter int SUM_WIDTH = 19
);
    logic                        valid;
    logic                        ready;
    logic signed [SUM_WIDTH-1:0] max_hourglass_sum;
    logic                        no_window;

    modport source (output valid, output max_hourglass_sum, output no_window, input ready);
    modport sink   (input valid, input max_hourglass_sum, input no_window, output ready);
endinterface

// File: rtl/hourglass_window_max_unit.sv
// hourglass window maximum: line stores, window taps, seven-term sum and running max
// the element marked last is registered in stage one, then its result in the result register
// throughput: one element per cycle; stalls only while a last element waits on a held result
// line store read data is registered; a write bypass covers a read of the entry being written
// reset: async active low; clears counters, taps, maximum and output valid, row length to 3
// line stores are not cleared and hold no valid bits
module hourglass_window_max_unit #(
    parameter int MAX_COLUMNS   = 1024,
    parameter int ELEMENT_WIDTH = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write_en,
    input  logic [hgw_pkg::ROW_LENGTH_W-1:0] cfg_write_data,
    hgw_element_if.sink                    element,
    hgw_result_if.source                   result
);
    import hgw_pkg::*;

    localparam int COL_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int LEN_W = COL_W + 1;
    localparam int EW    = ELEMENT_WIDTH;
    localparam int SW    = ELEMENT_WIDTH + SUM_GROWTH_W;

    // configuration register
    logic [ROW_LENGTH_W-1:0] row_length_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_length_reg <= ROW_LENGTH_W'(ROW_LENGTH_RESET);
        end
        else if (cfg_write_en)
        begin
            row_length_reg <= cfg_write_data;
        end
    end

    // effective row length, clamped to the supported range
    logic [LEN_W-1:0] eff_len;

    always_comb
    begin
        if (32'(row_length_reg) < 32'(MIN_ROW_LENGTH))
        begin
            eff_len = LEN_W'(MIN_ROW_LENGTH);
        end
        else if (32'(row_length_reg) > 32'(MAX_COLUMNS))
        begin
            eff_len = LEN_W'(MAX_COLUMNS);
        end
        else
        begin
            eff_len = LEN_W'(row_length_reg);
        end
    end

    // handshake and stage control
    logic s1_valid_reg;
    logic s1_last_reg;
    logic out_valid_reg;
    logic s1_go;
    logic accept;

    assign s1_go  = s1_valid_reg && (!s1_last_reg || !out_valid_reg || result.ready);
    assign element.ready = !s1_valid_reg || s1_go;
    assign accept = element.valid && element.ready;

    // position tracking at the transfer
    logic [COL_W-1:0] col_reg;
    logic [1:0]       rows_reg;
    logic             wrap;

    assign wrap = ({1'b0, col_reg} + LEN_W'(1)) >= eff_len;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            rows_reg <= '0;
        end
        else if (accept)
        begin
            if (element.last_element)
            begin
                col_reg  <= '0;
                rows_reg <= '0;
            end
            else if (wrap)
            begin
                col_reg <= '0;
                if (rows_reg < 2'(WINDOW_ROWS - 1))
                begin
                    rows_reg <= rows_reg + 2'd1;
                end
            end
            else
            begin
                col_reg <= col_reg + COL_W'(1);
            end
        end
    end

    // stage one payload
    logic signed [EW-1:0] s1_elem_reg;
    logic [COL_W-1:0]     s1_pos_reg;
    logic                 s1_win_reg;
    logic signed [EW-1:0] top_rd_reg;
    logic signed [EW-1:0] mid_rd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_last_reg  <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
            s1_last_reg  <= element.last_element;
        end
        else if (s1_go)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_elem_reg <= element.element_value;
            s1_pos_reg  <= col_reg;
            s1_win_reg  <= (rows_reg >= 2'(WINDOW_ROWS - 1)) && (col_reg >= COL_W'(2));
        end
    end

    // line stores: read at the transfer, written when stage one retires
    logic signed [EW-1:0] row_above_mem [MAX_COLUMNS];
    logic signed [EW-1:0] two_above_mem [MAX_COLUMNS];
    logic                 fwd_hit;

    assign fwd_hit = s1_go && (s1_pos_reg == col_reg);

    always_ff @(posedge clk)
    begin
        if (s1_go)
        begin
            two_above_mem[s1_pos_reg] <= mid_rd_reg;
            row_above_mem[s1_pos_reg] <= s1_elem_reg;
        end
        if (accept)
        begin
            if (fwd_hit)
            begin
                top_rd_reg <= mid_rd_reg;
                mid_rd_reg <= s1_elem_reg;
            end
            else
            begin
                top_rd_reg <= two_above_mem[col_reg];
                mid_rd_reg <= row_above_mem[col_reg];
            end
        end
    end

    // window taps and running maximum
    logic signed [EW-1:0] top0_reg;
    logic signed [EW-1:0] top1_reg;
    logic signed [EW-1:0] mid_tap_reg;
    logic signed [EW-1:0] bot0_reg;
    logic signed [EW-1:0] bot1_reg;
    logic signed [SW-1:0] best_reg;
    logic                 seen_reg;

    // hourglass sum over the seven mask positions
    logic signed [SW-1:0] hg_sum;
    logic signed [SW-1:0] best_next;
    logic                 seen_next;

    assign hg_sum = SW'(top0_reg) + SW'(top1_reg) + SW'(top_rd_reg) + SW'(mid_tap_reg)
                  + SW'(bot0_reg) + SW'(bot1_reg) + SW'(s1_elem_reg);

    always_comb
    begin
        best_next = best_reg;
        seen_next = seen_reg;
        if (s1_win_reg)
        begin
            if (!seen_reg || (hg_sum > best_reg))
            begin
                best_next = hg_sum;
            end
            seen_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top0_reg    <= '0;
            top1_reg    <= '0;
            mid_tap_reg <= '0;
            bot0_reg    <= '0;
            bot1_reg    <= '0;
            best_reg    <= '0;
            seen_reg    <= 1'b0;
        end
        else if (s1_go)
        begin
            if (s1_last_reg)
            begin
                top0_reg    <= '0;
                top1_reg    <= '0;
                mid_tap_reg <= '0;
                bot0_reg    <= '0;
                bot1_reg    <= '0;
                best_reg    <= '0;
                seen_reg    <= 1'b0;
            end
            else
            begin
                top0_reg    <= top1_reg;
                top1_reg    <= top_rd_reg;
                mid_tap_reg <= mid_rd_reg;
                bot0_reg    <= bot1_reg;
                bot1_reg    <= s1_elem_reg;
                best_reg    <= best_next;
                seen_reg    <= seen_next;
            end
        end
    end

    // result register
    logic signed [SW-1:0] out_sum_reg;
    logic                 out_none_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_go && s1_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && s1_last_reg)
        begin
            out_sum_reg  <= seen_next ? best_next : '0;
            out_none_reg <= !seen_next;
        end
    end

    assign result.valid             = out_valid_reg;
    assign result.max_hourglass_sum = out_sum_reg;
    assign result.no_window         = out_none_reg;

endmodule

// File: tb/tb_hourglass_window_max_unit.sv
`timescale 1ns / 100ps
// self-checking testbench for the hourglass window maximum unit
module tb_hourglass_window_max_unit;

    import hgw_pkg::*;

    localparam int ELEM_W          = 16;
    localparam int SUM_W           = ELEM_W + SUM_GROWTH_W;
    localparam int MAX_COLS        = 1024;
    localparam int SETTLE_CYCLES   = 6;
    localparam int WATCHDOG_LIMIT  = 1000;
    localparam int RANDOM_BUDGET   = 30;

    typedef enum int {
        FILL_ANY,
        FILL_EXTREME,
        FILL_NEGATIVE,
        FILL_SMALL,
        FILL_HIGHEST,
        FILL_LOWEST
    } fill_style_t;

    typedef struct {
        logic signed [ELEM_W-1:0] value;
        logic                     last;
    } matrix_element_t;

    typedef struct {
        logic signed [SUM_W-1:0] max_sum;
        logic                    no_window;
    } hourglass_result_t;

    logic clk;
    logic rst_n;
    logic cfg_write_en;
    logic [ROW_LENGTH_W-1:0] cfg_write_data;

    hgw_element_if #(.ELEMENT_WIDTH(ELEM_W)) element_ch ();
    hgw_result_if #(.SUM_WIDTH(SUM_W)) result_ch ();

    hourglass_window_max_unit #(
        .MAX_COLUMNS(MAX_COLS),
        .ELEMENT_WIDTH(ELEM_W)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write_en(cfg_write_en),
        .cfg_write_data(cfg_write_data),
        .element(element_ch),
        .result(result_ch)
    );

    matrix_element_t   pending_elements[$];
    hourglass_result_t expected_maxima[$];
    int                mismatch_count = 0;
    bit                final_stretch = 1'b0;

    // shadow copy of the window datapath
    logic signed [ELEM_W-1:0] row_above [MAX_COLS];
    logic signed [ELEM_W-1:0] two_rows_above [MAX_COLS];
    logic signed [ELEM_W-1:0] top_taps [2];
    logic signed [ELEM_W-1:0] middle_tap;
    logic signed [ELEM_W-1:0] bottom_taps [2];
    int                       column_pos = 0;
    int                       full_rows = 0;
    int                       best_sum = 0;
    bit                       have_window = 1'b0;
    int unsigned              shadow_row_length = ROW_LENGTH_RESET;

    // driver and sink pacing state
    int              gap_left = 0;
    int              driver_steady = 0;
    int              driver_roll;
    int              stall_left = 0;
    int              sink_steady = 0;
    int              sink_roll;
    matrix_element_t next_element;
    hourglass_result_t want;
    int              idle_cycles = 0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int effective_columns(int unsigned raw_length);
        if (raw_length < MIN_ROW_LENGTH)
            return MIN_ROW_LENGTH;
        if (raw_length > MAX_COLS)
            return MAX_COLS;
        return raw_length;
    endfunction

    // advance the shadow window by one element, queue the maximum on the last one
    function automatic void track_hourglass(logic signed [ELEM_W-1:0] cur, logic last);
        int                       cols;
        int                       pos;
        int                       sum;
        logic signed [ELEM_W-1:0] top;
        logic signed [ELEM_W-1:0] mid;
        hourglass_result_t        res;
        cols = effective_columns(shadow_row_length);
        pos = (column_pos >= MAX_COLS) ? 0 : column_pos;
        top = two_rows_above[pos];
        mid = row_above[pos];

        if (full_rows >= 2 && pos >= 2)
        begin
            sum = int'(top_taps[0]) + int'(top_taps[1]) + int'(top) + int'(middle_tap)
                + int'(bottom_taps[0]) + int'(bottom_taps[1]) + int'(cur);
            if (!have_window || sum > best_sum)
                best_sum = sum;
            have_window = 1'b1;
        end

        two_rows_above[pos] = mid;
        row_above[pos] = cur;
        top_taps[0] = top_taps[1];
        top_taps[1] = top;
        middle_tap = mid;
        bottom_taps[0] = bottom_taps[1];
        bottom_taps[1] = cur;

        if (pos + 1 >= cols)
        begin
            column_pos = 0;
            if (full_rows < 2)
                full_rows++;
        end
        else
            column_pos = pos + 1;

        if (last)
        begin
            res.max_sum = have_window ? SUM_W'(best_sum) : '0;
            res.no_window = !have_window;
            expected_maxima.push_back(res);
            top_taps[0] = '0;
            top_taps[1] = '0;
            middle_tap = '0;
            bottom_taps[0] = '0;
            bottom_taps[1] = '0;
            column_pos = 0;
            full_rows = 0;
            best_sum = 0;
            have_window = 1'b0;
        end
    endfunction

    task automatic report_mismatch(string what, longint got, longint exp_value);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got,
                 exp_value);
        mismatch_count++;
    endtask

    function automatic logic signed [ELEM_W-1:0] pick_element(fill_style_t style);
        int pick;
        case (style)
            FILL_HIGHEST:  return {1'b0, {(ELEM_W-1){1'b1}}};
            FILL_LOWEST:   return {1'b1, {(ELEM_W-1){1'b0}}};
            FILL_EXTREME:
            begin
                pick = $urandom_range(0, 3);
                case (pick)
                    0:       return {1'b0, {(ELEM_W-1){1'b1}}};
                    1:       return {1'b1, {(ELEM_W-1){1'b0}}};
                    2:       return '0;
                    default: return '1;
                endcase
            end
            FILL_NEGATIVE: return {1'b1, (ELEM_W-1)'($urandom)};
            FILL_SMALL:
            begin
                pick = $urandom_range(0, 16);
                return ELEM_W'(pick - 8);
            end
            default:       return ELEM_W'($urandom);
        endcase
    endfunction

    task automatic queue_matrix(int count, fill_style_t style);
        matrix_element_t item;
        for (int i = 0; i < count; i++)
        begin
            item.value = pick_element(style);
            item.last = (i == count - 1);
            pending_elements.push_back(item);
        end
    endtask

    // elements without a last mark, for a matrix that continues after a pause
    task automatic queue_open_elements(int count);
        matrix_element_t item;
        for (int i = 0; i < count; i++)
        begin
            item.value = pick_element(FILL_ANY);
            item.last = 1'b0;
            pending_elements.push_back(item);
        end
    endtask

    // mostly whole matrices, some ending mid-row, some cut short at random
    task automatic queue_random_matrices(int unsigned raw_length, int budget);
        int          cols;
        int          rows;
        int          count;
        int          roll;
        int          queued;
        fill_style_t style;
        cols = effective_columns(raw_length);
        queued = 0;
        while (queued < budget)
        begin
            roll = $urandom_range(0, 19);
            rows = $urandom_range(3, 6);
            if (roll < 14)
                count = rows * cols;
            else if (roll < 17)
                count = rows * cols + $urandom_range(1, cols - 1);
            else
                count = $urandom_range(1, 3 * cols);
            style = fill_style_t'($urandom_range(0, 3));
            queue_matrix(count, style);
            queued += count;
        end
    endtask

    task automatic wait_until_drained();
        do
            @(negedge clk);
        while (pending_elements.size() != 0 || element_ch.valid
               || expected_maxima.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_row_length(int unsigned raw_length);
        wait_until_drained();
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_write_data <= ROW_LENGTH_W'(raw_length);
        @(posedge clk);
        cfg_write_en <= 1'b0;
        @(negedge clk);
    endtask

    // stimulus sequence
    initial
    begin
        rst_n = 1'b0;
        cfg_write_en = 1'b0;
        cfg_write_data = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: sum extremes, lone last element, two rows with no window
        queue_matrix(9, FILL_HIGHEST);
        queue_matrix(9, FILL_LOWEST);
        queue_matrix(1, FILL_HIGHEST);
        queue_matrix(6, FILL_EXTREME);

        // below-range register value acts as three columns
        write_row_length(0);
        queue_random_matrices(0, RANDOM_BUDGET);

        // widest raw value clamps to the store depth, the counter wraps at the top column
        write_row_length((1 << ROW_LENGTH_W) - 1);
        queue_matrix(MAX_COLS + 4, FILL_ANY);

        write_row_length(5);
        queue_random_matrices(5, RANDOM_BUDGET);

        // row length shrinks mid-row, the column counter wraps early
        write_row_length(8);
        queue_open_elements(2 * 8 + 6);
        write_row_length(4);
        queue_matrix(3 * 4, FILL_ANY);

        write_row_length(1);
        queue_random_matrices(1, RANDOM_BUDGET);

        write_row_length(7);
        queue_random_matrices(7, RANDOM_BUDGET);

        write_row_length(2);
        queue_random_matrices(2, RANDOM_BUDGET);

        write_row_length(16);
        queue_random_matrices(16, 2 * RANDOM_BUDGET);

        write_row_length(11);
        queue_random_matrices(11, RANDOM_BUDGET);

        write_row_length(6);
        queue_random_matrices(6, RANDOM_BUDGET);

        // closing stretch at full rate on both sides
        write_row_length(MIN_ROW_LENGTH);
        final_stretch = 1'b1;
        queue_random_matrices(MIN_ROW_LENGTH, RANDOM_BUDGET);

        wait_until_drained();
        if (mismatch_count == 0)
            $display("** hourglass_window_max_unit: PASSED **");
        else
            $display("** hourglass_window_max_unit: FAILED **");
        $finish;
    end

    // element driver: one pending element per free slot, random gap bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            element_ch.valid <= 1'b0;
            element_ch.element_value <= '0;
            element_ch.last_element <= 1'b0;
            gap_left = 0;
            driver_steady = 0;
        end
        else if (!element_ch.valid || element_ch.ready)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                element_ch.valid <= 1'b0;
            end
            else if (pending_elements.size() > 0)
            begin
                next_element = pending_elements.pop_front();
                element_ch.valid <= 1'b1;
                element_ch.element_value <= next_element.value;
                element_ch.last_element <= next_element.last;
                if (driver_steady > 0)
                    driver_steady--;
                else if (!final_stretch)
                begin
                    driver_roll = $urandom_range(0, 19);
                    if (driver_roll == 0)
                        driver_steady = $urandom_range(20, 120);
                    else if (driver_roll < 5)
                        gap_left = $urandom_range(1, 19);
                end
            end
            else
                element_ch.valid <= 1'b0;
        end
    end

    // result sink: random stall bursts, with long stretches of steady ready
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            stall_left = 0;
            sink_steady = 0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            result_ch.ready <= 1'b0;
        end
        else if (final_stretch || sink_steady > 0)
        begin
            if (sink_steady > 0)
                sink_steady--;
            result_ch.ready <= 1'b1;
        end
        else
        begin
            sink_roll = $urandom_range(0, 15);
            if (sink_roll == 0)
            begin
                sink_steady = $urandom_range(50, 400);
                result_ch.ready <= 1'b1;
            end
            else if (sink_roll < 5)
            begin
                stall_left = $urandom_range(1, 19) - 1;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    // register shadow, prediction on element transfers, checks on result transfers
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_write_en)
                shadow_row_length = 32'(cfg_write_data);

            if (element_ch.valid && element_ch.ready)
                track_hourglass(element_ch.element_value, element_ch.last_element);

            if (result_ch.valid && result_ch.ready)
            begin
                if (expected_maxima.size() == 0)
                    report_mismatch("unexpected result", result_ch.max_hourglass_sum, 0);
                else
                begin
                    want = expected_maxima.pop_front();
                    if (result_ch.max_hourglass_sum !== want.max_sum)
                        report_mismatch("max_hourglass_sum", result_ch.max_hourglass_sum,
                                        want.max_sum);
                    if (result_ch.no_window !== want.no_window)
                        report_mismatch("no_window", result_ch.no_window, want.no_window);
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || cfg_write_en || (element_ch.valid && element_ch.ready)
            || (result_ch.valid && result_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[%0t] no transfer for %0d cycles", $realtime, idle_cycles);
            $display("** hourglass_window_max_unit: FAILED **");
            $finish;
        end
    end

endmodule
